FILE: hw/rtl/pvdd_pkg.sv
// ----------------------------------------------------------------------------
// pvdd_pkg: shared types for the per-bucket volume drop detector
// Holds the bucket table entry, the candidate record handed to the event
// stage and the configuration register indexes.
// ----------------------------------------------------------------------------
package pvdd_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_LIQ_THRESH  = 3'd0,
        REG_DROP_RATIO  = 3'd1,
        REG_WINDOW      = 3'd2,
        REG_BUCKET_SHIFT = 3'd3,
        REG_BASE_PRICE  = 3'd4
    } cfg_reg_t;

    localparam int unsigned VOL_W   = 32;
    localparam int unsigned RATIO_W = 17;
    localparam int unsigned FRAC_W  = 16;
    localparam int unsigned PROD_W  = VOL_W + RATIO_W;

    // one bucket table entry: last snapshot seen in the bucket
    typedef struct packed {
        logic             valid;
        logic [31:0]      snap_time;
        logic [VOL_W-1:0] ask;
        logic [VOL_W-1:0] bid;
    } entry_t;

    // per-item candidate, both sides, before the final ratio compare
    typedef struct packed {
        logic [31:0]       snap_time;
        logic [31:0]       bucket_price;
        logic [VOL_W-1:0]  bid_before;
        logic [VOL_W-1:0]  bid_after;
        logic [VOL_W-1:0]  ask_before;
        logic [VOL_W-1:0]  ask_after;
        logic [VOL_W-1:0]  bid_drop;
        logic [VOL_W-1:0]  ask_drop;
        logic [PROD_W-1:0] bid_need;
        logic [PROD_W-1:0] ask_need;
        logic              bid_elig;
        logic              ask_elig;
    } cand_t;

endpackage

FILE: hw/rtl/per_bucket_volume_drop_detector_unit.sv
// ----------------------------------------------------------------------------
// per_bucket_volume_drop_detector_unit: liquidity sweep detector
// Maps each order-book snapshot to a price bucket, compares it with the
// bucket's last snapshot and emits a sweep event per side whose volume fell
// by at least the configured ratio.
//
//   channel   direction  transaction
//   s_axis    in         one snapshot: timestamp, price, bid and ask volume
//   m_axis    out        one sweep event, tlast on the final one of a snapshot
//   cfg       in         one register write: index and data
//
// A snapshot is taken every cycle while no stage stalls; the first event shows once it
// has passed the input register, table read, product register and event register.
// A snapshot with two events holds the event register until both are sent, so the
// output port sets the rate at one event per cycle while m_axis_tready stays high.
// After reset the table clearing pass walks every bucket with s_axis_tready low;
// configuration writes are taken throughout.
// Back-pressure on m_axis propagates back through every stage to s_axis_tready.
// ----------------------------------------------------------------------------
module per_bucket_volume_drop_detector_unit #(
    parameter int NUM_BUCKETS = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // timestamp_s, price_ticks, bid vol, ask vol (lowest bit up)
    input  logic [127:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // event_time, bucket_price, prior vol, current vol (lowest bit up)
    output logic [127:0]  m_axis_tdata,
    // is_bid
    output logic          m_axis_tuser,
    // last_of_run
    output logic          m_axis_tlast,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_data
);

    localparam int IDX_W = $clog2(NUM_BUCKETS);
    localparam int unsigned RW = pvdd_pkg::RATIO_W;
    localparam int unsigned PW = pvdd_pkg::PROD_W;

    // configuration registers
    logic [31:0]   liq_thresh_reg;
    logic [RW-1:0] drop_ratio_reg;
    logic [31:0]   window_reg;
    logic [4:0]    bucket_shift_reg;
    logic [31:0]   base_price_reg;

    // input stage
    logic        s1_valid_reg;
    logic [31:0] s1_ts_reg;
    logic [31:0] s1_price_reg;
    logic [31:0] s1_bid_reg;
    logic [31:0] s1_ask_reg;

    // table stage
    logic             s2_valid_reg;
    logic             s2_in_range_reg;
    logic [IDX_W-1:0] s2_idx_reg;
    logic [31:0]      s2_ts_reg;
    logic [31:0]      s2_bid_reg;
    logic [31:0]      s2_ask_reg;
    logic             fwd_hit_reg;
    pvdd_pkg::entry_t fwd_data_reg;

    // product stage
    logic            s3_valid_reg;
    pvdd_pkg::cand_t s3_cand_reg;

    // control and datapath
    logic             s1_adv;
    logic             s1_free;
    logic             s2_adv;
    logic             s2_free;
    logic             s3_adv;
    logic             s3_free;
    logic             ev_ready;
    logic             s_accept;
    logic             tbl_clearing;
    logic [31:0]      s1_diff;
    logic [31:0]      s1_idx_full;
    logic             s1_in_range;
    logic [IDX_W-1:0] s1_idx;
    pvdd_pkg::entry_t tbl_rd_data;
    pvdd_pkg::entry_t s2_entry;
    pvdd_pkg::entry_t s2_wr_data;
    logic             s2_wr_en;
    logic [31:0]      s2_age;
    logic             s2_in_win;
    logic             s2_usable;
    pvdd_pkg::cand_t  s2_cand;

    // stage flow, ready runs back from the event register
    assign s3_adv        = s3_valid_reg && ev_ready;
    assign s3_free       = !s3_valid_reg || s3_adv;
    assign s2_adv        = s2_valid_reg && s3_free;
    assign s2_free       = !s2_valid_reg || s2_adv;
    assign s1_adv        = s1_valid_reg && s2_free;
    assign s1_free       = !s1_valid_reg || s1_adv;
    assign s_axis_tready = s1_free && !tbl_clearing;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            liq_thresh_reg   <= 32'd0;
            drop_ratio_reg   <= RW'(32768);
            window_reg       <= 32'd60;
            bucket_shift_reg <= 5'd0;
            base_price_reg   <= 32'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pvdd_pkg::REG_LIQ_THRESH:   liq_thresh_reg   <= cfg_data;
                pvdd_pkg::REG_DROP_RATIO:   drop_ratio_reg   <= cfg_data[RW-1:0];
                pvdd_pkg::REG_WINDOW:       window_reg       <= cfg_data;
                pvdd_pkg::REG_BUCKET_SHIFT: bucket_shift_reg <= cfg_data[4:0];
                pvdd_pkg::REG_BASE_PRICE:   base_price_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= s_accept;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_adv;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_adv;
            end
            if (s1_adv)
            begin
                fwd_hit_reg <= s2_wr_en && (s2_idx_reg == s1_idx);
            end
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_ts_reg    <= s_axis_tdata[31:0];
            s1_price_reg <= s_axis_tdata[63:32];
            s1_bid_reg   <= s_axis_tdata[95:64];
            s1_ask_reg   <= s_axis_tdata[127:96];
        end
    end

    // bucket index from price
    assign s1_diff     = s1_price_reg - base_price_reg;
    assign s1_idx_full = s1_diff >> bucket_shift_reg;
    assign s1_in_range = (s1_price_reg >= base_price_reg)
                         && (s1_idx_full < 32'(NUM_BUCKETS));
    assign s1_idx      = s1_idx_full[IDX_W-1:0];

    // table stage payload, the write in flight is captured for forwarding
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_in_range_reg <= s1_in_range;
            s2_idx_reg      <= s1_idx;
            s2_ts_reg       <= s1_ts_reg;
            s2_bid_reg      <= s1_bid_reg;
            s2_ask_reg      <= s1_ask_reg;
            fwd_data_reg    <= s2_wr_data;
        end
    end

    pvdd_table #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .clearing (tbl_clearing),
        .rd_en    (s1_adv),
        .rd_addr  (s1_idx),
        .rd_data  (tbl_rd_data),
        .wr_en    (s2_wr_en),
        .wr_addr  (s2_idx_reg),
        .wr_data  (s2_wr_data)
    );

    // an in-range snapshot replaces the bucket entry when the item leaves this stage
    assign s2_wr_en   = s2_adv && s2_in_range_reg;
    assign s2_wr_data = '{valid: 1'b1, snap_time: s2_ts_reg,
                          ask: s2_ask_reg, bid: s2_bid_reg};
    assign s2_entry   = fwd_hit_reg ? fwd_data_reg : tbl_rd_data;

    // window test, time running backwards counts as age zero
    assign s2_age    = (s2_ts_reg >= s2_entry.snap_time)
                       ? (s2_ts_reg - s2_entry.snap_time) : 32'd0;
    assign s2_in_win = (s2_age <= window_reg);
    assign s2_usable = s2_in_range_reg && s2_entry.valid && s2_in_win;

    // per side eligibility and ratio product
    always_comb
    begin
        s2_cand.snap_time    = s2_ts_reg;
        s2_cand.bucket_price = base_price_reg
            + ({{(32-IDX_W){1'b0}}, s2_idx_reg} << bucket_shift_reg);
        s2_cand.bid_before   = s2_entry.bid;
        s2_cand.bid_after    = s2_bid_reg;
        s2_cand.ask_before   = s2_entry.ask;
        s2_cand.ask_after    = s2_ask_reg;
        s2_cand.bid_drop     = s2_entry.bid - s2_bid_reg;
        s2_cand.ask_drop     = s2_entry.ask - s2_ask_reg;
        s2_cand.bid_need     = PW'(drop_ratio_reg) * PW'(s2_entry.bid);
        s2_cand.ask_need     = PW'(drop_ratio_reg) * PW'(s2_entry.ask);
        s2_cand.bid_elig     = s2_usable && (s2_entry.bid > liq_thresh_reg)
                               && (s2_bid_reg < s2_entry.bid);
        s2_cand.ask_elig     = s2_usable && (s2_entry.ask > liq_thresh_reg)
                               && (s2_ask_reg < s2_entry.ask);
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            s3_cand_reg <= s2_cand;
        end
    end

    pvdd_event_out u_event_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s3_valid_reg),
        .in_ready      (ev_ready),
        .cand          (s3_cand_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clearing pass owns the table alone
    a_clear_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_clearing |-> (!s1_valid_reg && !s2_valid_reg && !s2_wr_en))
        else $error("table access during clearing pass");

    // only a bid event can be followed by another event of the same snapshot
    a_first_is_bid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> m_axis_tuser)
        else $error("non-final event is not bid side");

    // taking the bid event of a pair leaves the ask event as the final one
    a_pair_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast)
        |=> (m_axis_tvalid && !m_axis_tuser && m_axis_tlast))
        else $error("second event of a pair missing");

    // forwarded entry always carries a valid snapshot
    a_fwd_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && fwd_hit_reg) |-> fwd_data_reg.valid)
        else $error("forwarded entry without valid flag");

endmodule

FILE: hw/rtl/pvdd_table.sv
// ----------------------------------------------------------------------------
// pvdd_table: bucket snapshot table
// One write port and one registered read port; after reset a clearing pass
// walks every entry once and drops its valid flag.
// ----------------------------------------------------------------------------
module pvdd_table #(
    parameter int NUM_BUCKETS = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    output logic                             clearing,
    input  logic                             rd_en,
    input  logic [$clog2(NUM_BUCKETS)-1:0]   rd_addr,
    output pvdd_pkg::entry_t                 rd_data,
    input  logic                             wr_en,
    input  logic [$clog2(NUM_BUCKETS)-1:0]   wr_addr,
    input  pvdd_pkg::entry_t                 wr_data
);

    localparam int IDX_W = $clog2(NUM_BUCKETS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUCKETS - 1);

    pvdd_pkg::entry_t mem [NUM_BUCKETS];
    pvdd_pkg::entry_t rd_data_reg;
    logic             clr_active_reg;
    logic             clr_active_next;
    logic [IDX_W-1:0] clr_cnt_reg;
    logic [IDX_W-1:0] clr_cnt_next;

    // clearing pass sequencing
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_cnt_next    = clr_cnt_reg;
        if (clr_active_reg)
        begin
            if (clr_cnt_reg == LAST_IDX)
            begin
                clr_active_next = 1'b0;
            end
            else
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_cnt_reg    <= clr_cnt_next;
        end
    end

    // storage write, clearing pass has priority
    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clr_active_reg;

endmodule

FILE: hw/rtl/pvdd_event_out.sv
// ----------------------------------------------------------------------------
// pvdd_event_out: sweep decision and event output register
// Finishes the ratio compare for both sides and presents zero, one or two
// events, bid side first, on the master stream.
// ----------------------------------------------------------------------------
module pvdd_event_out (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  pvdd_pkg::cand_t cand,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    // event_time, bucket_price, prior vol, current vol (lowest bit up)
    output logic [127:0]    m_axis_tdata,
    // is_bid
    output logic            m_axis_tuser,
    // last_of_run
    output logic            m_axis_tlast
);

    localparam int unsigned PW = pvdd_pkg::PROD_W;
    localparam int unsigned VW = pvdd_pkg::VOL_W;
    localparam int unsigned FW = pvdd_pkg::FRAC_W;

    pvdd_pkg::cand_t hold_reg;
    logic            pend_bid_reg;
    logic            pend_ask_reg;
    logic            fire_bid;
    logic            fire_ask;
    logic [PW-1:0]   bid_scaled;
    logic [PW-1:0]   ask_scaled;
    logic            out_fire;
    logic            load;

    // drop scaled by 2^16 against ratio times before
    assign bid_scaled = {{(PW-VW-FW){1'b0}}, cand.bid_drop, {FW{1'b0}}};
    assign ask_scaled = {{(PW-VW-FW){1'b0}}, cand.ask_drop, {FW{1'b0}}};
    assign fire_bid   = cand.bid_elig && (bid_scaled >= cand.bid_need);
    assign fire_ask   = cand.ask_elig && (ask_scaled >= cand.ask_need);

    // handshake on both sides
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign in_ready = !(pend_bid_reg || pend_ask_reg)
                      || (out_fire && (pend_bid_reg ^ pend_ask_reg));
    assign load     = in_valid && in_ready;

    // pending event flags, a new load replaces the event being sent
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_bid_reg <= 1'b0;
            pend_ask_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                pend_bid_reg <= fire_bid;
                pend_ask_reg <= fire_ask;
            end
            else if (out_fire)
            begin
                if (pend_bid_reg)
                begin
                    pend_bid_reg <= 1'b0;
                end
                else
                begin
                    pend_ask_reg <= 1'b0;
                end
            end
        end
    end

    // event payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hold_reg <= cand;
        end
    end

    // output select, bid side goes first
    assign m_axis_tvalid = pend_bid_reg || pend_ask_reg;
    assign m_axis_tuser  = pend_bid_reg;
    assign m_axis_tlast  = !(pend_bid_reg && pend_ask_reg);
    assign m_axis_tdata  = pend_bid_reg
        ? {hold_reg.bid_after, hold_reg.bid_before,
           hold_reg.bucket_price, hold_reg.snap_time}
        : {hold_reg.ask_after, hold_reg.ask_before,
           hold_reg.bucket_price, hold_reg.snap_time};

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: per-bucket volume drop detector testbench
// Feeds order-book snapshots under several register settings and handshake
// patterns. A scoreboard predicts the sweep events that each accepted snapshot
// should produce and checks every event leaving the block in order.
// ----------------------------------------------------------------------------
module tb;

    localparam int NUM_BUCKETS  = 256;
    localparam int DRAIN_CYCLES = 12;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    // one predicted sweep event
    typedef struct packed {
        logic [31:0] event_time;
        logic [31:0] bucket_price;
        logic [31:0] vol_before;
        logic [31:0] vol_after;
        logic        is_bid;
        logic        last_of_run;
    } sweep_t;

    // bucket table shadow, register copy and queue of predicted sweeps
    class sweep_scoreboard;
        bit          slot_used [NUM_BUCKETS];
        logic [31:0] slot_bid [NUM_BUCKETS];
        logic [31:0] slot_ask [NUM_BUCKETS];
        logic [31:0] slot_time [NUM_BUCKETS];
        logic [31:0] thresh;
        logic [16:0] ratio;
        logic [31:0] window;
        logic [4:0]  shift;
        logic [31:0] base;
        sweep_t      sweeps_q[$];
        int          errors;
        int          snapshots;
        int          outside;
        int          events;
        int          settings;

        function new();
            foreach (slot_used[i])
                slot_used[i] = 1'b0;
            thresh = 32'd0;
            ratio = 17'd32768;
            window = 32'd60;
            shift = 5'd0;
            base = 32'd0;
            errors = 0;
            snapshots = 0;
            outside = 0;
            events = 0;
            settings = 0;
        endfunction

        function void set_reg(pvdd_pkg::cfg_reg_t idx, logic [31:0] data);
            settings++;
            case (idx)
                pvdd_pkg::REG_LIQ_THRESH:   thresh = data;
                pvdd_pkg::REG_DROP_RATIO:   ratio = data[16:0];
                pvdd_pkg::REG_WINDOW:       window = data;
                pvdd_pkg::REG_BUCKET_SHIFT: shift = data[4:0];
                pvdd_pkg::REG_BASE_PRICE:   base = data;
                default: ;
            endcase
        endfunction

        // map a price to its table slot, 0 when it falls outside the table
        function bit bucket_of(logic [31:0] price, output int slot);
            logic [31:0] rel;
            slot = 0;
            if (price < base)
                return 1'b0;
            rel = (price - base) >> shift;
            if (rel >= NUM_BUCKETS)
                return 1'b0;
            slot = int'(rel);
            return 1'b1;
        endfunction

        // exact ratio test: drop * 2^16 >= ratio * prior volume
        function bit is_sweep(logic [31:0] prev_vol, logic [31:0] cur_vol);
            logic [63:0] drop_scaled;
            logic [63:0] need;
            if (prev_vol <= thresh || cur_vol >= prev_vol)
                return 1'b0;
            drop_scaled = {32'd0, prev_vol - cur_vol} << 16;
            need = {47'd0, ratio} * {32'd0, prev_vol};
            return drop_scaled >= need;
        endfunction

        // accepted snapshot: predict sweeps, then update the bucket
        function void note_snapshot(logic [127:0] data);
            logic [31:0] ts;
            logic [31:0] price;
            logic [31:0] bid;
            logic [31:0] ask;
            logic [31:0] age;
            logic [31:0] bprice;
            int          slot;
            int          n;
            sweep_t      ev;
            ts = data[31:0];
            price = data[63:32];
            bid = data[95:64];
            ask = data[127:96];
            snapshots++;
            if (!bucket_of(price, slot))
            begin
                outside++;
                return;
            end
            bprice = base + (32'(slot) << shift);
            n = 0;
            if (slot_used[slot])
            begin
                age = (ts >= slot_time[slot]) ? ts - slot_time[slot] : 32'd0;
                if (age <= window)
                begin
                    if (is_sweep(slot_bid[slot], bid))
                    begin
                        ev = '{ts, bprice, slot_bid[slot], bid, 1'b1, 1'b0};
                        sweeps_q.insert(sweeps_q.size(), ev);
                        n++;
                    end
                    if (is_sweep(slot_ask[slot], ask))
                    begin
                        ev = '{ts, bprice, slot_ask[slot], ask, 1'b0, 1'b0};
                        sweeps_q.insert(sweeps_q.size(), ev);
                        n++;
                    end
                    if (n > 0)
                        sweeps_q[sweeps_q.size() - 1].last_of_run = 1'b1;
                end
            end
            slot_used[slot] = 1'b1;
            slot_bid[slot] = bid;
            slot_ask[slot] = ask;
            slot_time[slot] = ts;
        endfunction

        function void cmp(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
            end
        endfunction

        // event leaving the block: compare with the oldest prediction
        function void check_event(logic [127:0] data, logic user, logic last);
            sweep_t want;
            if (sweeps_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected event, expected none, got %h user %b last %b",
                         $time, data, user, last);
                return;
            end
            want = sweeps_q.pop_front();
            events++;
            cmp("event_time", want.event_time, data[31:0]);
            cmp("bucket_price", want.bucket_price, data[63:32]);
            cmp("prior volume", want.vol_before, data[95:64]);
            cmp("current volume", want.vol_after, data[127:96]);
            cmp("is_bid", {31'd0, want.is_bid}, {31'd0, user});
            cmp("last_of_run", {31'd0, want.last_of_run}, {31'd0, last});
        endfunction
    endclass

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [127:0]  s_axis_tdata = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [127:0]  m_axis_tdata;
    logic          m_axis_tuser;
    logic          m_axis_tlast;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [2:0]    cfg_index = '0;
    logic [31:0]   cfg_data = '0;

    idle_mode_t      idle_mode = IDLE_NONE;
    logic            draining = 1'b0;
    logic [31:0]     cur_time = 32'd0;
    sweep_scoreboard sb = new;

    per_bucket_volume_drop_detector_unit #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    // run limit
    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    // sample every transaction at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_reg(pvdd_pkg::cfg_reg_t'(cfg_index), cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_snapshot(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_event(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    // event receiver with random stalls
    always @(negedge clk)
    begin
        m_axis_tready <= draining
            || ($urandom_range(0, 99) >= ((idle_mode == IDLE_RECV) ? 65 :
                                          (idle_mode == IDLE_BOTH) ? 26 : 0));
    end

    // one register write; valid stays high for the caller to lower
    task automatic cfg_write(input pvdd_pkg::cfg_reg_t idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_settings(input logic [31:0] thr, input logic [31:0] ratio,
                                  input logic [31:0] win, input logic [31:0] sh,
                                  input logic [31:0] bp);
        cfg_write(pvdd_pkg::REG_LIQ_THRESH, thr);
        cfg_write(pvdd_pkg::REG_DROP_RATIO, ratio);
        cfg_write(pvdd_pkg::REG_WINDOW, win);
        cfg_write(pvdd_pkg::REG_BUCKET_SHIFT, sh);
        cfg_write(pvdd_pkg::REG_BASE_PRICE, bp);
        cfg_valid <= 1'b0;
    endtask

    // one snapshot transaction, with random idle cycles ahead of it
    task automatic send_snapshot(input logic [31:0] ts, input logic [31:0] price,
                                 input logic [31:0] bid, input logic [31:0] ask);
        while ($urandom_range(0, 99) < ((idle_mode == IDLE_SEND) ? 65 :
                                        (idle_mode == IDLE_BOTH) ? 26 : 0))
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {ask, bid, price, ts};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // wait out every predicted event, then let the pipeline empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.sweeps_q.size() != 0)
            @(negedge clk);
        draining <= 1'b1;
        repeat (DRAIN_CYCLES) @(negedge clk);
        draining <= 1'b0;
    endtask

    // next volume for a bucket, often near the ratio boundary
    function automatic logic [31:0] next_volume(input logic [31:0] prev);
        int unsigned r;
        logic [63:0] cut;
        logic [31:0] v;
        r = $urandom_range(0, 99);
        if (r < 35)
        begin
            cut = ({32'd0, prev} * {47'd0, sb.ratio}) >> 16;
            v = prev - cut[31:0];
            case ($urandom_range(0, 2))
                0: v = v - 32'd1;
                2: v = v + 32'd1;
                default: ;
            endcase
        end
        else if (r < 60)
            v = $urandom_range(0, prev);
        else if (r < 80)
            v = $urandom;
        else if (r < 88)
            v = prev;
        else
        begin
            case ($urandom_range(0, 3))
                0: v = 32'd0;
                1: v = 32'hFFFF_FFFF;
                2: v = sb.thresh;
                default: v = sb.thresh + 32'd1;
            endcase
        end
        return v;
    endfunction

    // edge cases under base 1000, 16-tick buckets, window 100
    task automatic run_directed();
        send_snapshot(32'd10, 32'd999, 32'hFFFF_FFFF, 32'hFFFF_FFFF);   // below base
        send_snapshot(32'd10, 32'd0, 32'd5, 32'd5);                     // price zero
        send_snapshot(32'd10, 32'd5096, 32'd7, 32'd7);                  // past last bucket
        send_snapshot(32'd10, 32'hFFFF_FFFF, 32'd7, 32'd7);             // price max
        send_snapshot(32'd10, 32'd1000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // empty bucket
        send_snapshot(32'd20, 32'd1015, 32'd0, 32'h7FFF_FFFF);          // both sides drop
        send_snapshot(32'd20, 32'd1015, 32'd5, 32'h7FFF_FFFF);          // rising and flat
        send_snapshot(32'd15, 32'd1001, 32'd2, 32'd0);                  // time goes back
        send_snapshot(32'd200, 32'd5095, 32'd1000, 32'd1000);           // last bucket
        send_snapshot(32'd300, 32'd5080, 32'd500, 32'd501);             // exact half, age = window
        send_snapshot(32'd401, 32'd5090, 32'd0, 32'd0);                 // stale entry
        send_snapshot(32'd401, 32'd5090, 32'd0, 32'd0);                 // zero to zero
        send_snapshot(32'd500, 32'd1016, 32'd0, 32'd100);               // bucket one
        send_snapshot(32'd500, 32'd1031, 32'd0, 32'd49);                // ask side only
        send_snapshot(32'hFFFF_FFFF, 32'd1032, 32'd10, 32'd10);         // time max
        send_snapshot(32'd0, 32'd1047, 32'd9, 32'd3);                   // wrap, age zero
        send_snapshot(32'hFFFF_FFF0, 32'd1032, 32'hAAAA_AAAA, 32'h5555_5555);
        send_snapshot(32'hFFFF_FFF8, 32'd1040, 32'h5555_5555, 32'hAAAA_AAAA);
    endtask

    // target random snapshots, mostly on buckets that keep being revisited
    task automatic run_random(input int target);
        int          slot;
        int unsigned r;
        int unsigned cap;
        logic [31:0] idx;
        logic [31:0] off;
        logic [31:0] price;
        logic [31:0] bid;
        logic [31:0] ask;
        for (int k = 0; k < target; k++)
        begin
            // advance time: mostly inside the window, some stale, some backwards
            r = $urandom_range(0, 99);
            cap = (sb.window < 40) ? sb.window : 40;
            if (r < 70)
                cur_time = cur_time + $urandom_range(0, cap);
            else if (r < 85)
                cur_time = cur_time + sb.window + 32'd1 + $urandom_range(0, 5);
            else if (r < 93)
                cur_time = cur_time - $urandom_range(1, 30);
            else
                cur_time = $urandom;
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                // well-formed snapshot on a frequently revisited bucket
                r = $urandom_range(0, 99);
                idx = (r < 60) ? $urandom_range(0, 7) :
                      (r < 80) ? $urandom_range(NUM_BUCKETS - 8, NUM_BUCKETS - 1) :
                                 $urandom_range(0, NUM_BUCKETS - 1);
                off = (sb.shift == 0) ? 32'd0 : ($urandom & ((32'd1 << sb.shift) - 32'd1));
                price = sb.base + (idx << sb.shift) + off;
                if (sb.bucket_of(price, slot) && sb.slot_used[slot])
                begin
                    bid = next_volume(sb.slot_bid[slot]);
                    ask = next_volume(sb.slot_ask[slot]);
                end
                else
                begin
                    bid = next_volume($urandom);
                    ask = next_volume($urandom);
                end
            end
            else
            begin
                // noise and prices just outside the table
                if (r < 90)
                    price = $urandom;
                else if (r < 95)
                    price = sb.base - $urandom_range(1, 1000);
                else
                    price = sb.base + (32'(NUM_BUCKETS) << sb.shift) + $urandom_range(0, 1000);
                bid = $urandom;
                ask = $urandom;
            end
            send_snapshot(cur_time, price, bid, ask);
        end
    endtask

    // main sequence
    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        write_settings(32'd0, 32'd32768, 32'd100, 32'd4, 32'd1000);
        run_directed();
        settle();
        for (int p = 0; p < 8; p++)
        begin
            idle_mode <= idle_mode_t'(p % 4);
            case (p)
                0: write_settings(32'd0, 32'd32768, 32'd60, 32'd0, 32'd0);
                1: write_settings(32'd1000, 32'd0, 32'd1000, 32'd3, 32'd5000);
                2: write_settings(32'hFFFF_FFFF, 32'd40000, 32'd20, 32'd8, 32'h0001_0000);
                3: write_settings(32'd0, 32'd65536, 32'hFFFF_FFFF, 32'd1, 32'd100);
                4: write_settings(32'h8000_0000, 32'd65535, 32'd0, 32'd31, 32'h8000_0000);
                5: write_settings(32'd12345, 32'd16384, 32'd5, 32'd0, 32'hFFFF_FFFF);
                6: write_settings(32'd0, 32'd1, 32'd300, 32'd5, 32'hFFFF_0000);
                default: write_settings(32'd500, 32'd49152, 32'd60, 32'd12, 32'h00A0_0000);
            endcase
            run_random((p == 5) ? 60 : 165);
            settle();
        end
        $display("run covered %0d snapshots (%0d outside the bucket table) and %0d sweep events",
                 sb.snapshots, sb.outside, sb.events);
        $display("over %0d register writes and four handshake patterns; %0d mismatches",
                 sb.settings, sb.errors);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
